[design/lmdt_pkg.sv]
// ---------------------------------------------------------------------------
// lmdt_pkg
// Shared types and constants of the local-mean depth threshold block.
// ---------------------------------------------------------------------------
package lmdt_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int DEPTH_W    = 16;
  localparam int SCALE_W    = 25;
  localparam int MEAN_FRAC  = 24;
  localparam int THR_W      = 32;
  localparam int GEOM_W     = 11;
  localparam int HALF_W     = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HALF     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MEAN_SCALE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_THRESHOLD = 3'd4;

  // squared deviation weight
  localparam logic [13:0] DEV_WEIGHT = 14'd10000;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth_mm;
    logic               flush;
  } pix_in_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] object_depth;
    logic               object_valid;
    logic [DEPTH_W-1:0] background_depth;
    logic               background_valid;
    logic               on_border;
    logic               frame_end;
  } pix_out_t;

  typedef enum logic [10:0] {
    ST_CLEAR = 11'b000_0000_0001,
    ST_IDLE  = 11'b000_0000_0010,
    ST_READ  = 11'b000_0000_0100,
    ST_LOOK  = 11'b000_0000_1000,
    ST_WIN   = 11'b000_0001_0000,
    ST_TAIL  = 11'b000_0010_0000,
    ST_MUL1  = 11'b000_0100_0000,
    ST_MUL2  = 11'b000_1000_0000,
    ST_DEV   = 11'b001_0000_0000,
    ST_CMP   = 11'b010_0000_0000,
    ST_OUT   = 11'b100_0000_0000
  } state_e;

endpackage

[design/lmdt_if.sv]
// ---------------------------------------------------------------------------
// lmdt_if
// Valid/ready channels for depth pixels in and classified pixels out.
// ---------------------------------------------------------------------------
interface lmdt_in_if;
  import lmdt_pkg::*;
  logic    valid;
  logic    ready;
  pix_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lmdt_out_if;
  import lmdt_pkg::*;
  logic     valid;
  logic     ready;
  pix_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/local_mean_depth_threshold.sv]
// ---------------------------------------------------------------------------
// local_mean_depth_threshold
// Box-window local-mean threshold on raster depth pixels, ring line store.
// ---------------------------------------------------------------------------
// One item at a time. An item with no result passes READ and LOOK and returns to IDLE;
// a border pixel goes on to OUT; an inner pixel does one ring-memory read per window
// pixel in WIN, then TAIL and the mean and compare multiplier steps before OUT.
// Reset starts a clearing pass over every entry of the line store; a geometry
// write runs the same pass on pending bits.
module local_mean_depth_threshold #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_HALF   = 3
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lmdt_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lmdt_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  lmdt_in_if.sink                           in_i,
  lmdt_out_if.source                        out_o
);
  import lmdt_pkg::*;

  localparam int RING  = 2 * MAX_HALF * MAX_WIDTH + 2 * MAX_HALF + 1;
  localparam int AW    = $clog2(RING);
  localparam int CW    = $clog2(MAX_WIDTH + 1);
  localparam int RW    = $clog2(MAX_HEIGHT + 1);
  localparam int HW    = $clog2(MAX_HALF + 1);
  localparam int SW    = $clog2(2 * MAX_HALF + 1);
  localparam int SUM_W = $clog2((2 * MAX_HALF + 1) * (2 * MAX_HALF + 1) * 65535 + 1);
  localparam int PW    = SUM_W + SCALE_W;
  localparam int CMP_W = 48;

  function automatic logic [AW-1:0] madd(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (AW+1)'(RING)) s = s - (AW+1)'(RING);
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] msub(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    if (a >= b) s = {1'b0, a} - {1'b0, b};
    else        s = {1'b0, a} + (AW+1)'(RING) - {1'b0, b};
    return s[AW-1:0];
  endfunction

  // configuration
  logic [GEOM_W-1:0]  fw_q, fh_q;
  logic [HALF_W-1:0]  wh_q;
  logic [SCALE_W-1:0] scale_q;
  logic [THR_W-1:0]   thr_q;
  logic               geom_wr;

  assign geom_wr = cfg_we_i && (cfg_idx_i == REG_FRAME_WIDTH ||
                   cfg_idx_i == REG_FRAME_HEIGHT || cfg_idx_i == REG_WINDOW_HALF);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q    <= GEOM_W'(640);
      fh_q    <= GEOM_W'(480);
      wh_q    <= '0;
      scale_q <= SCALE_W'(1 << MEAN_FRAC);
      thr_q   <= THR_W'(5);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FRAME_WIDTH:     fw_q    <= cfg_data_i[GEOM_W-1:0];
        REG_FRAME_HEIGHT:    fh_q    <= cfg_data_i[GEOM_W-1:0];
        REG_WINDOW_HALF:     wh_q    <= cfg_data_i[HALF_W-1:0];
        REG_MEAN_SCALE:      scale_q <= cfg_data_i[SCALE_W-1:0];
        REG_ERROR_THRESHOLD: thr_q   <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // effective geometry
  logic [CW-1:0] w_eff;
  logic [RW-1:0] h_eff;
  logic [HW-1:0] half;
  logic [AW-1:0] lag;

  always_comb begin
    if (fw_q == '0)                       w_eff = CW'(1);
    else if (32'(fw_q) > MAX_WIDTH)       w_eff = CW'(MAX_WIDTH);
    else                                  w_eff = CW'(fw_q);
    if (fh_q == '0)                       h_eff = RW'(1);
    else if (32'(fh_q) > MAX_HEIGHT)      h_eff = RW'(MAX_HEIGHT);
    else                                  h_eff = RW'(fh_q);
    if (32'(wh_q) > MAX_HALF)             half = HW'(MAX_HALF);
    else                                  half = HW'(wh_q);
  end

  assign lag = AW'(half) * AW'(w_eff) + AW'(half);

  // ring memories
  logic [DEPTH_W-1:0] line_mem [RING];
  logic               pend_mem [RING];
  logic [DEPTH_W-1:0] line_rd_q;
  logic               pend_rd_q;
  logic               line_we, pend_we, pend_wd;
  logic [AW-1:0]      line_wa, pend_wa, rd_addr;
  logic [DEPTH_W-1:0] line_wd;

  state_e             state_q;
  logic [AW-1:0]      clr_q, head_q, p_q, win_addr_q, row_addr_q;
  logic               clr_data_q, acc_vld_q;
  logic [SW-1:0]      dr_q, dc_q;
  logic [CW-1:0]      oc_q;
  logic [RW-1:0]      or_q;
  logic               out_valid_q;
  pix_out_t           out_q;
  logic               in_fire, out_load, border;
  logic [SW-1:0]      side_m1;

  assign in_fire  = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_o.ready);
  assign side_m1  = SW'({half, 1'b0});

  assign border = (oc_q < CW'(half)) || (or_q < RW'(half)) ||
                  ((RW+1)'(or_q) + (RW+1)'(half) >= (RW+1)'(h_eff)) ||
                  ((CW+1)'(oc_q) + (CW+1)'(half) >= (CW+1)'(w_eff));

  always_comb begin
    line_we = 1'b0; line_wa = head_q; line_wd = in_i.data.depth_mm;
    pend_we = 1'b0; pend_wa = head_q; pend_wd = !in_i.data.flush;
    if (state_q == ST_CLEAR) begin
      line_we = clr_data_q; line_wa = clr_q; line_wd = '0;
      pend_we = 1'b1;       pend_wa = clr_q; pend_wd = 1'b0;
    end else if (in_fire) begin
      line_we = 1'b1;
      line_wd = in_i.data.flush ? '0 : in_i.data.depth_mm;
      pend_we = 1'b1;
    end else if (state_q == ST_LOOK && pend_rd_q) begin
      pend_we = 1'b1; pend_wa = p_q; pend_wd = 1'b0;
    end
    rd_addr = (state_q == ST_WIN) ? win_addr_q : p_q;
  end

  always_ff @(posedge clk_i) begin
    if (line_we) line_mem[line_wa] <= line_wd;
    if (pend_we) pend_mem[pend_wa] <= pend_wd;
    line_rd_q <= line_mem[rd_addr];
    pend_rd_q <= pend_mem[rd_addr];
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      clr_data_q  <= 1'b1;
      head_q      <= '0;
      oc_q        <= '0;
      or_q        <= '0;
      out_valid_q <= 1'b0;
      acc_vld_q   <= 1'b0;
    end else begin
      acc_vld_q <= (state_q == ST_WIN);
      if (out_load)          out_valid_q <= 1'b1;
      else if (out_o.ready)  out_valid_q <= 1'b0;
      if (geom_wr) begin
        state_q <= ST_CLEAR;
        clr_q   <= '0;
        oc_q    <= '0;
        or_q    <= '0;
      end else begin
        unique case (state_q)
          ST_CLEAR: begin
            if (clr_q == AW'(RING - 1)) begin
              state_q    <= ST_IDLE;
              clr_data_q <= 1'b0;
            end else begin
              clr_q <= clr_q + 1'b1;
            end
          end
          ST_IDLE: begin
            if (in_fire) begin
              head_q  <= madd(head_q, AW'(1));
              state_q <= ST_READ;
            end
          end
          ST_READ: state_q <= ST_LOOK;
          ST_LOOK: begin
            if (!pend_rd_q)  state_q <= ST_IDLE;
            else if (border) state_q <= ST_OUT;
            else             state_q <= ST_WIN;
          end
          ST_WIN: begin
            if (dc_q == side_m1 && dr_q == side_m1) state_q <= ST_TAIL;
          end
          ST_TAIL: state_q <= ST_MUL1;
          ST_MUL1: state_q <= ST_MUL2;
          ST_MUL2: state_q <= ST_DEV;
          ST_DEV:  state_q <= ST_CMP;
          ST_CMP:  state_q <= ST_OUT;
          ST_OUT: begin
            if (out_load) begin
              state_q <= ST_IDLE;
              if (oc_q == w_eff - 1'b1) begin
                oc_q <= '0;
                or_q <= (or_q == h_eff - 1'b1) ? '0 : or_q + 1'b1;
              end else begin
                oc_q <= oc_q + 1'b1;
              end
            end
          end
          default: state_q <= ST_IDLE;
        endcase
      end
    end
  end

  // datapath
  logic [DEPTH_W-1:0] d_q, m_q, dev;
  logic               border_q;
  logic [SUM_W-1:0]   sum_q;
  logic [SUM_W+15:0]  plo_q;
  logic [PW-1:0]      prod;
  logic [PW-MEAN_FRAC-1:0] mq;
  logic [31:0]        dd_q;
  logic [CMP_W-1:0]   lhs_q, rhs_q;
  logic               is_obj;
  pix_out_t           res;
  logic [AW-1:0]      row_next;

  // high scale bits times the sum, kept at full width before the shift
  assign prod = PW'(plo_q) + ((PW'(sum_q) * PW'(scale_q[SCALE_W-1:16])) << 16);
  assign mq   = prod[PW-1:MEAN_FRAC];
  assign dev  = (d_q >= m_q) ? d_q - m_q : m_q - d_q;
  assign row_next = madd(row_addr_q, AW'(w_eff));

  always_ff @(posedge clk_i) begin
    if (in_fire) p_q <= msub(head_q, lag);
    if (state_q == ST_LOOK) begin
      d_q        <= line_rd_q;
      border_q   <= border;
      sum_q      <= '0;
      dr_q       <= '0;
      dc_q       <= '0;
      win_addr_q <= msub(p_q, lag);
      row_addr_q <= msub(p_q, lag);
    end else begin
      if (acc_vld_q) sum_q <= sum_q + SUM_W'(line_rd_q);
      if (state_q == ST_WIN) begin
        if (dc_q == side_m1) begin
          dc_q       <= '0;
          dr_q       <= dr_q + 1'b1;
          row_addr_q <= row_next;
          win_addr_q <= row_next;
        end else begin
          dc_q       <= dc_q + 1'b1;
          win_addr_q <= madd(win_addr_q, AW'(1));
        end
      end
    end
    if (state_q == ST_MUL1) plo_q <= sum_q * scale_q[15:0];
    if (state_q == ST_MUL2) m_q <= (mq > (PW-MEAN_FRAC)'(65535)) ? 16'hFFFF : mq[15:0];
    if (state_q == ST_DEV)  dd_q <= 32'(dev) * 32'(dev);
    if (state_q == ST_CMP) begin
      lhs_q <= CMP_W'(dd_q) * CMP_W'(DEV_WEIGHT);
      rhs_q <= CMP_W'(thr_q) * CMP_W'(m_q);
    end
    if (out_load) out_q <= res;
  end

  always_comb begin
    is_obj = (m_q == '0) ? (d_q != '0) : (lhs_q > rhs_q);
    res = '0;
    res.on_border = border_q;
    res.frame_end = (oc_q == w_eff - 1'b1) && (or_q == h_eff - 1'b1);
    if (border_q) begin
      res.background_depth = d_q;
      res.background_valid = 1'b1;
    end else if (is_obj) begin
      res.object_depth = d_q;
      res.object_valid = 1'b1;
    end else begin
      res.background_depth = m_q;
      res.background_valid = 1'b1;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

[dv/local_mean_depth_threshold_test.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// local_mean_depth_threshold_test
// Streams depth frames through the local-mean threshold block under several
// geometries, window sizes, scales and thresholds, with random stalls on both
// channels. A built-in predictor of the window mean and the object/background
// split checks every result in order.
// ---------------------------------------------------------------------------
module local_mean_depth_threshold_test;
  import lmdt_pkg::*;

  localparam int MAX_W      = 1024;
  localparam int MAX_H      = 1024;
  localparam int MAX_HF     = 3;
  localparam int RING_LEN   = 2 * MAX_HF * MAX_W + 2 * MAX_HF + 1;
  localparam int STALL_MAX  = 30000;
  localparam int ITEM_GOAL  = 1250;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = REG_ERROR_THRESHOLD + 3'd1;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  lmdt_in_if  pix_in ();
  lmdt_out_if pix_out ();

  local_mean_depth_threshold DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (pix_in),
    .out_o      (pix_out)
  );

  // predictor state
  int unsigned     geo_width, geo_height, geo_half, scale_q24, err_limit;
  logic [15:0]     depth_ring [RING_LEN];
  bit              ring_pending [RING_LEN];
  int              ring_head, in_col, in_row, out_col, out_row;

  pix_in_t  pixel_queue[$];
  pix_out_t classified_q[$];

  int idle_in_pct, idle_out_pct;
  int errors, pixels_sent, flushes_sent, results_seen;
  int objects_seen, border_seen, frames_seen;
  int stall_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int clamp_dim(int unsigned v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic void step_pos(ref int col, ref int row, input int w, input int ht);
    col++;
    if (col >= w) begin
      col = 0;
      row++;
      if (row >= ht) row = 0;
    end
  endfunction

  function automatic void drop_pending();
    foreach (ring_pending[i]) ring_pending[i] = 1'b0;
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  function automatic void classify_pixel(pix_in_t x);
    int w, ht, hw, lag, p, idx;
    logic [15:0] d;
    bit border, is_obj;
    longint unsigned sum, m, dev, lhs, rhs;
    pix_out_t e;
    w = clamp_dim(geo_width, MAX_W);
    ht = clamp_dim(geo_height, MAX_H);
    hw = (geo_half > MAX_HF) ? MAX_HF : geo_half;
    lag = hw * w + hw;
    depth_ring[ring_head] = x.flush ? 16'd0 : x.depth_mm;
    ring_pending[ring_head] = !x.flush;
    if (!x.flush) step_pos(in_col, in_row, w, ht);
    p = (ring_head + RING_LEN - lag) % RING_LEN;
    ring_head = (ring_head + 1) % RING_LEN;
    if (!ring_pending[p]) return;
    ring_pending[p] = 1'b0;
    e = '0;
    d = depth_ring[p];
    border = out_row < hw || out_col < hw || out_row + hw >= ht || out_col + hw >= w;
    e.on_border = border;
    if (border) begin
      e.background_depth = d;
      e.background_valid = 1'b1;
    end else begin
      sum = 0;
      for (int dr = -hw; dr <= hw; dr++) begin
        for (int dc = -hw; dc <= hw; dc++) begin
          idx = (p + RING_LEN + dr * w + dc) % RING_LEN;
          sum += depth_ring[idx];
        end
      end
      m = (sum * scale_q24) >> MEAN_FRAC;
      if (m > 65535) m = 65535;
      if (m == 0) begin
        is_obj = d != 0;
      end else begin
        dev = (d >= m) ? d - m : m - d;
        lhs = dev * dev * 10000;
        rhs = longint'(err_limit) * m;
        is_obj = lhs > rhs;
      end
      if (is_obj) begin
        e.object_depth = d;
        e.object_valid = 1'b1;
      end else begin
        e.background_depth = m[15:0];
        e.background_valid = 1'b1;
      end
    end
    e.frame_end = (out_row == ht - 1) && (out_col == w - 1);
    step_pos(out_col, out_row, w, ht);
    classified_q.push_back(e);
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni && (!pix_in.valid || pix_in.ready)) begin
      if (pixel_queue.size() > 0 && $urandom_range(99) >= idle_in_pct) begin
        pix_in.valid <= 1'b1;
        pix_in.data  <= pixel_queue.pop_front();
      end else begin
        pix_in.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) pix_out.ready <= ($urandom_range(99) >= idle_out_pct);
  end

  // monitor
  always @(posedge clk_i) begin
    pix_out_t got, want;
    if (rst_ni) begin
      if (pix_in.valid && pix_in.ready) begin
        if (pix_in.data.flush) flushes_sent++;
        else pixels_sent++;
        classify_pixel(pix_in.data);
      end
      if (pix_out.valid && pix_out.ready) begin
        got = pix_out.data;
        results_seen++;
        if (classified_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, actual %p", $time, got);
        end else begin
          want = classified_q.pop_front();
          if (got.object_depth !== want.object_depth
              || got.object_valid !== want.object_valid
              || got.background_depth !== want.background_depth
              || got.background_valid !== want.background_valid
              || got.on_border !== want.on_border
              || got.frame_end !== want.frame_end) begin
            errors++;
            $display("%0t: mismatch, expected %p actual %p", $time, want, got);
          end
          if (want.object_valid) objects_seen++;
          if (want.on_border) border_seen++;
          if (want.frame_end) frames_seen++;
        end
      end
    end
  end

  // watchdog: cycles with no transfer on either channel
  always @(posedge clk_i) begin
    if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_MAX) begin
      $display("timeout after %0d cycles without a transfer", stall_count);
      $display("local_mean_depth_threshold_test: FAIL");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      REG_FRAME_WIDTH: begin
        geo_width = val[10:0];
        drop_pending();
      end
      REG_FRAME_HEIGHT: begin
        geo_height = val[10:0];
        drop_pending();
      end
      REG_WINDOW_HALF: begin
        geo_half = val[1:0];
        drop_pending();
      end
      REG_MEAN_SCALE:      scale_q24 = val[24:0];
      REG_ERROR_THRESHOLD: err_limit = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    wait (pixel_queue.size() == 0 && !pix_in.valid);
    wait (classified_q.size() == 0);
    // flush items and dropped pixels finish without a result
    repeat (100) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_depth(int base);
    int sel, v;
    sel = $urandom_range(99);
    if (sel < 8) return 16'd0;
    if (sel < 13) return 16'hFFFF;
    if (sel < 30) return 16'($urandom_range(65535));
    v = base + $urandom_range(40) - 20;
    if (sel < 40) v = base + $urandom_range(2000) - 1000;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  task automatic add_item(logic [15:0] d, bit fl);
    pix_in_t x;
    x.depth_mm = d;
    x.flush = fl;
    pixel_queue.push_back(x);
  endtask

  task automatic setup(int unsigned w, int unsigned ht, int unsigned hw,
                       int unsigned sc, int unsigned thr);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, ht);
    write_reg(REG_WINDOW_HALF, hw);
    write_reg(REG_MEAN_SCALE, sc);
    write_reg(REG_ERROR_THRESHOLD, thr);
  endtask

  // pixels, optional flushes inside, then, if drain is set, enough flushes to drain the lag
  task automatic send_frame(int npix, int flush_pct, bit drain);
    int w, hw, base;
    w = clamp_dim(geo_width, MAX_W);
    hw = (geo_half > MAX_HF) ? MAX_HF : geo_half;
    base = $urandom_range(65535);
    for (int i = 0; i < npix; i++) begin
      if ($urandom_range(99) < flush_pct) add_item(16'($urandom_range(65535)), 1'b1);
      add_item(pick_depth(base), 1'b0);
    end
    if (drain) begin
      for (int i = 0; i < hw * w + hw; i++) add_item(16'($urandom_range(65535)), 1'b1);
    end
    wait_idle();
  endtask

  initial begin
    int unsigned w, ht, hw, sc, thr;
    int sel;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    pix_in.valid = 1'b0;
    pix_in.data = '0;
    pix_out.ready = 1'b0;
    errors = 0;
    pixels_sent = 0;
    flushes_sent = 0;
    results_seen = 0;
    objects_seen = 0;
    border_seen = 0;
    frames_seen = 0;
    stall_count = 0;
    idle_in_pct = 21;
    idle_out_pct = 45;
    geo_width = 640;
    geo_height = 480;
    geo_half = 0;
    scale_q24 = 1 << 24;
    err_limit = 5;
    ring_head = 0;
    foreach (depth_ring[i]) depth_ring[i] = '0;
    drop_pending();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: 5x5 frame, 3x3 window, zero threshold, extreme depths
    setup(5, 5, 1, (1 << 24) / 9, 0);
    add_item(16'h1234, 1'b1);  // flush with nothing pending
    for (int i = 0; i < 13; i++) add_item(i[0] ? 16'hFFFF : 16'd0, 1'b0);
    add_item(16'd0, 1'b1);     // flush inside the frame
    for (int i = 0; i < 12; i++) add_item(16'(1000 + i), 1'b0);
    for (int i = 0; i < 6; i++) add_item(16'd0, 1'b1);
    wait_idle();
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    // zero and oversized geometry, zero scale, max threshold
    setup(0, 2047, 0, 0, 32'hFFFF_FFFF);
    add_item(16'd0, 1'b0);
    add_item(16'd7, 1'b0);
    wait_idle();
    setup(2047, 1, 3, 1 << 24, 5);
    add_item(16'hFFFF, 1'b0);
    add_item(16'd1, 1'b0);
    wait_idle();
    // window larger than frame; left pending, dropped by the next write
    setup(3, 3, 3, (1 << 24) / 49, 100);
    for (int i = 0; i < 4; i++) add_item(16'hA5A5 ^ 16'(i), 1'b0);
    wait_idle();

    while (pixels_sent + flushes_sent < ITEM_GOAL) begin
      if (pixels_sent + flushes_sent > 2 * ITEM_GOAL / 3) begin
        idle_in_pct = 0;
        idle_out_pct = 0;
      end else if (pixels_sent + flushes_sent > ITEM_GOAL / 3) begin
        idle_in_pct = 45;
        idle_out_pct = 21;
      end
      w = $urandom_range(1, 12);
      ht = $urandom_range(1, 10);
      hw = $urandom_range(0, 3);
      sel = $urandom_range(9);
      if (sel < 6) sc = (1 << 24) / ((2 * hw + 1) * (2 * hw + 1));
      else if (sel < 7) sc = 1 << 24;
      else if (sel < 8) sc = 0;
      else sc = $urandom_range((1 << 25) - 1);
      sel = $urandom_range(9);
      if (sel < 5) thr = $urandom_range(50);
      else if (sel < 7) thr = $urandom_range(1 << 20);
      else if (sel < 8) thr = 32'hFFFF_FFFF;
      else thr = $urandom;
      setup(w, ht, hw, sc, thr);
      send_frame($urandom_range(1, 2 * w * ht), ($urandom_range(3) == 0) ? 8 : 0,
                 $urandom_range(7) != 0);
    end
    // final phase always drains
    setup(8, 8, 3, (1 << 24) / 49, 5);
    send_frame(64, 0, 1'b1);
    repeat (200) @(posedge clk_i);

    $display("covered %0d pixels and %0d flush items, %0d results checked",
             pixels_sent, flushes_sent, results_seen);
    $display("  %0d objects, %0d border pixels, %0d frame ends",
             objects_seen, border_seen, frames_seen);
    if (errors == 0 && classified_q.size() == 0) begin
      $display("local_mean_depth_threshold_test: PASS");
    end else begin
      $display("%0d errors, %0d results still expected", errors, classified_q.size());
      $display("local_mean_depth_threshold_test: FAIL");
    end
    $finish;
  end

endmodule
